FILE: rtl/core/cursor_sequence_store_core_assert.svh
// Assertion macros shared by the cursor sequence store RTL.
`ifndef CURSOR_SEQUENCE_STORE_CORE_ASSERT_SVH
`define CURSOR_SEQUENCE_STORE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cursor sequence store: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cursor sequence store: next-cycle check failed");

`endif

FILE: rtl/core/csstore_pkg.sv
// Types and constants of the cursor sequence store.
`timescale 1ns / 1ps
`default_nettype none

package csstore_pkg;

    // Position field wide enough for any supported depth (up to 256 plus "none").
    localparam int POS_W = 9;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;
    localparam int VALUE_W     = 64;
    localparam int COUNT_W     = 6;

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_ADVANCE = 3'd1,
        ACT_INSERT  = 3'd2,
        ACT_ATTACH  = 3'd3,
        ACT_REMOVE  = 3'd4,
        ACT_QUERY   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_kind;

    // Broadcast to every cell of the row.
    typedef struct packed {
        t_cell_kind        kind;
        logic [POS_W-1:0]  pos;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/csstore_cell.sv
// One storage cell of the entry row; shifts with its neighbors on insert/remove.
`timescale 1ns / 1ps
`default_nettype none

module csstore_cell
    import csstore_pkg::*;
#(
    parameter int WORD_WIDTH = 64,
    parameter int INDEX      = 0
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [WORD_WIDTH-1:0] i_value,
    input  wire logic [WORD_WIDTH-1:0] i_left,
    input  wire logic [WORD_WIDTH-1:0] i_right,
    output logic      [WORD_WIDTH-1:0] o_word
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.kind)
            CELL_INSERT: begin
                if (MY_POS == i_ctl.pos) begin
                    n_word = i_value;
                end else if (MY_POS > i_ctl.pos) begin
                    n_word = i_left;
                end
            end
            CELL_REMOVE: begin
                if (MY_POS >= i_ctl.pos) begin
                    n_word = i_right;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

FILE: rtl/core/cursor_sequence_store_core.sv
// Cursor sequence store: a row of shifting cells plus cursor and count control.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-------------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready | i_s_tdata: action[2:0], value[66:3]
//  m       | out | o_m_tvalid / i_m_tready | o_m_tdata: current_value[63:0],
//          |     |                         |   has_current[64], count[70:65], accepted[71]
//
// An accepted transaction updates every cell, the cursor and the count in that same edge;
// the cursor is read into the output register when the pending result is loaded.
// Throughput is one transaction per cycle while the master side takes results;
// accept sets the pending flag; its load into the output register raises o_m_tvalid.
// When a result is pending and the output register is full and not taken, o_s_tready drops.
// Synchronous active-low reset empties the store and clears o_m_tvalid and the pending flag.
`timescale 1ns / 1ps
`default_nettype none
`include "cursor_sequence_store_core_assert.svh"

module cursor_sequence_store_core
    import csstore_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int WORD_WIDTH = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // action[2:0], value[66:3], zero pad
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic      [OUT_TDATA_W-1:0] o_m_tdata    // current_value, has_current,
                                                      // count, accepted
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [WORD_WIDTH-1:0] w_word [DEPTH];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_cursor;
    logic [CW-1:0]         n_cursor;
    logic                  r_pend;
    logic                  r_pend_acc;
    logic                  n_acc;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    t_action               s_action;
    logic [WORD_WIDTH-1:0] s_value;
    logic                  s_in_acc;
    logic                  s_out_free;
    logic                  s_load;
    logic [CW-1:0]         s_adv_cur;
    logic [CW-1:0]         s_ins_base;
    logic [CW-1:0]         s_ins_pos;
    logic                  s_has;
    logic [WORD_WIDTH-1:0] s_cur_word;
    t_cell_ctl             s_ctl;

    assign s_action   = t_action'(i_s_tdata[2:0]);
    assign s_value    = WORD_WIDTH'(i_s_tdata[66:3]);
    assign s_out_free = !r_out_valid || i_m_tready;
    assign s_load     = r_pend && s_out_free;
    assign o_s_tready = !r_pend || s_out_free;
    assign s_in_acc   = i_s_tvalid && o_s_tready;

    // Cursor after an advance; on the last entry or beyond it parks at the count.
    assign s_adv_cur  = (r_count != '0 && r_cursor < r_count - 1'b1) ?
                        r_cursor + 1'b1 : r_count;
    assign s_ins_base = (s_action == ACT_ATTACH && r_count != '0) ? s_adv_cur : r_cursor;
    assign s_ins_pos  = (r_count == '0)        ? '0 :
                        (s_ins_base > r_count) ? r_count : s_ins_base;

    always_comb begin
        n_count    = r_count;
        n_cursor   = r_cursor;
        n_acc      = 1'b1;
        s_ctl.kind = CELL_HOLD;
        s_ctl.pos  = POS_W'(r_cursor);
        if (s_in_acc) begin
            unique case (s_action)
                ACT_START: begin
                    if (r_count != '0) begin
                        n_cursor = '0;
                    end
                end
                ACT_ADVANCE: begin
                    n_cursor = s_adv_cur;
                end
                ACT_INSERT, ACT_ATTACH: begin
                    if (r_count >= FULL) begin
                        n_acc = 1'b0;
                    end else begin
                        n_cursor   = s_ins_pos;
                        n_count    = r_count + 1'b1;
                        s_ctl.kind = CELL_INSERT;
                        s_ctl.pos  = POS_W'(s_ins_pos);
                    end
                end
                ACT_REMOVE: begin
                    if (r_cursor < r_count) begin
                        n_count    = r_count - 1'b1;
                        s_ctl.kind = CELL_REMOVE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_left;
        logic [WORD_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end
        csstore_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (s_ctl),
            .i_value (s_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[g])
        );
    end

    assign s_has      = r_cursor < r_count;
    assign s_cur_word = s_has ? w_word[r_cursor[IW-1:0]] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= FULL;
            r_pend      <= 1'b0;
            r_pend_acc  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
            if (s_in_acc) begin
                r_pend     <= 1'b1;
                r_pend_acc <= n_acc;
            end else if (s_load) begin
                r_pend <= 1'b0;
            end
            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_out_data <= {r_pend_acc, COUNT_W'(r_count), s_has, VALUE_W'(s_cur_word)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `CSS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL)
    `CSS_ASSERT_NOW(a_cursor_bound, i_clk, i_rst_n, 1'b1, r_cursor <= FULL)
    `CSS_ASSERT_NEXT(a_full_refused, i_clk, i_rst_n,
        s_in_acc && r_count == FULL && (s_action == ACT_INSERT || s_action == ACT_ATTACH),
        r_count == FULL && !r_pend_acc)
    `CSS_ASSERT_NEXT(a_pend_kept, i_clk, i_rst_n, r_pend && !s_out_free, r_pend)

endmodule

`default_nettype wire

FILE: tb/cursor_sequence_store_core_tb.sv
// Self-checking testbench for the cursor sequence store core: stream stimulus and result checks.
`timescale 1ns / 1ps

module cursor_sequence_store_core_tb
    import csstore_pkg::*;
;

    localparam int          STORE_DEPTH   = 32;
    localparam int          RANDOM_ITEMS  = 1850;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DRAIN_CYCLES  = 12;
    localparam int          IDLE_PERCENT  = 9;
    // Codes outside the enum; the block treats them as a query.
    localparam logic [2:0]  ACT_SPARE_LO  = 3'd6;
    localparam logic [2:0]  ACT_SPARE_HI  = 3'd7;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } t_mode;

    // Result word, msb first: accepted[71], count[70:65], has_current[64], current_value[63:0]
    typedef struct packed {
        logic               accepted;
        logic [COUNT_W-1:0] count;
        logic               has_current;
        logic [VALUE_W-1:0] current_value;
    } t_view;

    class cursor_store_tracker;
        logic [VALUE_W-1:0] slots [STORE_DEPTH];
        int                 fill;
        int                 cur;
        t_view              views_due [$];
        int                 errors;

        function new();
            fill   = 0;
            cur    = STORE_DEPTH;
            errors = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function void step_forward();
            if (fill > 0 && cur < fill - 1)
                cur++;
            else
                cur = fill;
        endfunction

        function void place_word(logic [VALUE_W-1:0] val);
            if (fill == 0) begin
                cur = 0;
            end else begin
                if (cur > fill)
                    cur = fill;
                for (int i = fill; i > cur; i--)
                    slots[i] = slots[i-1];
            end
            fill++;
            slots[cur] = val;
        endfunction

        // Apply one accepted transaction and queue the view it should produce.
        function void note_accepted(logic [2:0] act, logic [VALUE_W-1:0] val);
            t_view v;
            v.accepted = 1'b1;
            case (act)
                ACT_START: begin
                    if (fill > 0)
                        cur = 0;
                end
                ACT_ADVANCE: step_forward();
                ACT_INSERT, ACT_ATTACH: begin
                    if (fill >= STORE_DEPTH) begin
                        v.accepted = 1'b0;
                    end else begin
                        if (act == ACT_ATTACH && fill > 0)
                            step_forward();
                        place_word(val);
                    end
                end
                ACT_REMOVE: begin
                    if (cur < fill) begin
                        for (int i = cur; i + 1 < fill; i++)
                            slots[i] = slots[i+1];
                        fill--;
                    end
                end
                default: ;
            endcase
            v.has_current   = (cur < fill);
            v.current_value = v.has_current ? slots[cur] : '0;
            v.count         = COUNT_W'(fill);
            views_due.push_back(v);
        endfunction

        function void check_view(logic [OUT_TDATA_W-1:0] tdata);
            t_view got;
            t_view want;
            got = t_view'(tdata);
            if (views_due.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h", $time, tdata);
                errors++;
                return;
            end
            want = views_due.pop_front();
            if (got.current_value !== want.current_value) begin
                $display("%0t: current_value mismatch, expected %h actual %h",
                         $time, want.current_value, got.current_value);
                errors++;
            end
            if (got.has_current !== want.has_current) begin
                $display("%0t: has_current mismatch, expected %b actual %b",
                         $time, want.has_current, got.has_current);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: count mismatch, expected %0d actual %0d",
                         $time, want.count, got.count);
                errors++;
            end
            if (got.accepted !== want.accepted) begin
                $display("%0t: accepted mismatch, expected %b actual %b",
                         $time, want.accepted, got.accepted);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;   // action[2:0], value[66:3], zero pad
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;         // current_value, has_current, count, accepted

    cursor_store_tracker    tracker = new();
    bit                     quiet_phase = 1'b0;
    int                     cycle_count = 0;

    cursor_sequence_store_core #(
        .DEPTH      (STORE_DEPTH),
        .WORD_WIDTH (VALUE_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_m_tready  <= quiet_phase || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.check_view(o_m_tdata);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_item(input logic [2:0] act, input logic [VALUE_W-1:0] val);
        if (!quiet_phase && $urandom_range(99) < IDLE_PERCENT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - VALUE_W - 3){1'b0}}, val, act};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        tracker.note_accepted(act, val);
    endtask

    function automatic logic [VALUE_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(7);
        case (sel)
            0:       return '0;
            1:       return '1;
            2:       return VALUE_W'(1) << $urandom_range(VALUE_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [2:0] pick_action(t_mode mode);
        int roll;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL: begin
                if (roll < 35)      return ACT_INSERT;
                else if (roll < 70) return ACT_ATTACH;
                else if (roll < 80) return ACT_ADVANCE;
                else if (roll < 85) return ACT_START;
                else if (roll < 90) return ACT_REMOVE;
                else if (roll < 95) return ACT_QUERY;
                else                return roll[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
            end
            MODE_DRAIN: begin
                if (roll < 55)      return ACT_REMOVE;
                else if (roll < 70) return ACT_START;
                else if (roll < 80) return ACT_ADVANCE;
                else if (roll < 85) return ACT_INSERT;
                else if (roll < 90) return ACT_ATTACH;
                else if (roll < 95) return ACT_QUERY;
                else                return roll[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
            end
            default: return 3'($urandom_range(7));
        endcase
    endfunction

    initial begin
        t_mode mode;
        int    seg_left;

        mode     = MODE_FILL;
        seg_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty store: every action that needs an entry does nothing.
        send_item(ACT_QUERY,    '1);
        send_item(ACT_START,    '0);
        send_item(ACT_ADVANCE,  '0);
        send_item(ACT_REMOVE,   '0);
        send_item(ACT_SPARE_LO, '1);
        send_item(ACT_SPARE_HI, '0);
        // Attach on empty acts as insert at position 0.
        send_item(ACT_ATTACH,   '1);
        send_item(ACT_INSERT,   '0);
        send_item(ACT_ADVANCE,  '0);
        send_item(ACT_ADVANCE,  '0);
        send_item(ACT_ADVANCE,  '0);
        // No current entry: insert appends, attach appends too.
        send_item(ACT_INSERT,   64'hAAAA_AAAA_AAAA_AAAA);
        send_item(ACT_ADVANCE,  '0);
        send_item(ACT_ATTACH,   64'h5555_5555_5555_5555);
        send_item(ACT_START,    '0);
        send_item(ACT_ATTACH,   64'h8000_0000_0000_0001);
        send_item(ACT_REMOVE,   '0);
        send_item(ACT_ADVANCE,  '0);
        send_item(ACT_ADVANCE,  '0);
        // Removing the last entry leaves no current entry.
        send_item(ACT_REMOVE,   '0);
        send_item(ACT_REMOVE,   '0);
        send_item(ACT_QUERY,    '0);
        send_item(ACT_START,    '0);
        send_item(ACT_REMOVE,   '0);

        // Fill and drain phases push the store to full and back to empty.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_phase = (n >= 700 && n < 1000);
            if (seg_left == 0) begin
                mode     = t_mode'($urandom_range(2));
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            send_item(pick_action(mode), pick_word());
        end
        i_s_tvalid <= 1'b0;

        while (tracker.views_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.views_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
